// File: src/hsh_pkg.sv
package hsh_pkg;

   // stall detection needs this many plus one slow ticks in a row
   localparam int unsigned STALL_TICKS = 100;
   localparam int unsigned COUNT_W     = 8;
   localparam int unsigned DATA_W      = 32;
   localparam int unsigned LIMIT_W     = 31;
   localparam int unsigned CSR_IDX_W   = 3;

   localparam logic signed [COUNT_W-1:0] STALL_INIT = COUNT_W'(STALL_TICKS);

   // csr register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CENTRE_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RETURN_MODE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STALL_LIMIT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_SPD  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RETURN_TGT  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ARRIVE_TOL  = 3'd5;

   typedef enum logic [1:0] {
      PH_START = 2'd0,
      PH_POS   = 2'd1,
      PH_NEG   = 2'd2,
      PH_CAL   = 2'd3
   } phase_type;

   typedef struct packed {
      logic                      centre_mode;
      logic                      return_mode;
      logic [LIMIT_W-1:0]        stall_speed_limit;
      logic signed [DATA_W-1:0]  search_speed;
      logic signed [DATA_W-1:0]  return_target;
      logic [LIMIT_W-1:0]        arrive_tolerance;
   } cfg_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  joint_speed;
      logic signed [DATA_W-1:0]  joint_pos;
      logic signed [DATA_W-1:0]  actuator_pos;
      logic signed [DATA_W-1:0]  offset_now;
      logic                      halted;
   } req_type;

   typedef struct packed {
      logic                      loop_select;
      logic signed [DATA_W-1:0]  loop_error;
      logic                      offset_write;
      logic signed [DATA_W-1:0]  offset_new;
      phase_type                 phase;
      logic                      success;
   } rsp_type;

endpackage

// File: src/hsh_csr.sv
module hsh_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [hsh_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hsh_pkg::DATA_W-1:0]       csr_wdata,
   output hsh_pkg::cfg_type                 cfg
);
   import hsh_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid && csr_ready;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_index)
            CSR_CENTRE_MODE: cfg_in.centre_mode       = csr_wdata[0];
            CSR_RETURN_MODE: cfg_in.return_mode       = csr_wdata[0];
            CSR_STALL_LIMIT: cfg_in.stall_speed_limit = csr_wdata[LIMIT_W-1:0];
            CSR_SEARCH_SPD:  cfg_in.search_speed      = csr_wdata;
            CSR_RETURN_TGT:  cfg_in.return_target     = csr_wdata;
            CSR_ARRIVE_TOL:  cfg_in.arrive_tolerance  = csr_wdata[LIMIT_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.centre_mode       <= 1'b0;
         cfg_ff.return_mode       <= 1'b0;
         cfg_ff.stall_speed_limit <= LIMIT_W'(65536);
         cfg_ff.search_speed      <= DATA_W'(65536);
         cfg_ff.return_target     <= '0;
         cfg_ff.arrive_tolerance  <= LIMIT_W'(65536);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: src/hsh_step.sv
module hsh_step (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  hsh_pkg::req_type   req,
   input  hsh_pkg::cfg_type   cfg,
   output hsh_pkg::rsp_type   rsp,
   output logic               done
);
   import hsh_pkg::*;

   phase_type                 phase_ff, phase_in;
   logic signed [COUNT_W-1:0] stall_ff, stall_in;
   logic [DATA_W-1:0]         first_ff, first_in;
   logic [DATA_W-1:0]         setpoint_ff, setpoint_in;
   logic                      done_ff, done_in;

   logic [DATA_W-1:0]         speed_mag;
   logic                      slow;
   logic                      count_slow;
   logic [DATA_W:0]           stop_sum;
   logic [DATA_W-1:0]         mid;
   logic [DATA_W:0]           pos_diff;
   logic [DATA_W:0]           pos_mag;
   logic                      arrived;

   // magnitude as unsigned, so the most negative speed is never slow
   assign speed_mag  = req.joint_speed[DATA_W-1] ? DATA_W'(-req.joint_speed)
                                                 : req.joint_speed;
   assign slow       = speed_mag < {1'b0, cfg.stall_speed_limit};
   assign count_slow = slow && !(phase_ff == PH_POS && req.halted);

   // floor of the exact sum over two
   assign stop_sum = {first_ff[DATA_W-1], first_ff}
                   + {req.actuator_pos[DATA_W-1], req.actuator_pos};
   assign mid      = stop_sum[DATA_W:1];

   assign pos_diff = {req.joint_pos[DATA_W-1], req.joint_pos}
                   - {cfg.return_target[DATA_W-1], cfg.return_target};
   assign pos_mag  = pos_diff[DATA_W] ? -pos_diff : pos_diff;
   assign arrived  = pos_mag < {2'b00, cfg.arrive_tolerance};

   always_comb begin
      phase_in         = phase_ff;
      stall_in         = stall_ff;
      first_in         = first_ff;
      setpoint_in      = setpoint_ff;
      done_in          = done_ff;
      rsp.loop_select  = 1'b0;
      rsp.loop_error   = '0;
      rsp.offset_write = 1'b0;
      rsp.offset_new   = '0;
      unique case (phase_ff)
         PH_START: begin
            setpoint_in = cfg.search_speed;
            stall_in    = STALL_INIT;
            phase_in    = PH_POS;
         end
         PH_POS, PH_NEG: begin
            stall_in = count_slow ? stall_ff - COUNT_W'(1) : STALL_INIT;
            if (stall_in[COUNT_W-1]) begin
               setpoint_in = '0;
               if (phase_ff == PH_POS && cfg.centre_mode) begin
                  first_in    = req.actuator_pos;
                  stall_in    = STALL_INIT;
                  setpoint_in = -cfg.search_speed;
                  phase_in    = PH_NEG;
               end else begin
                  rsp.offset_new   = (phase_ff == PH_POS) ? req.offset_now - req.actuator_pos
                                                          : req.offset_now - mid;
                  rsp.offset_write = 1'b1;
                  phase_in         = PH_CAL;
                  if (!cfg.return_mode) begin
                     done_in = 1'b1;
                  end
               end
            end
            rsp.loop_error = setpoint_in - req.joint_speed;
         end
         PH_CAL: begin
            if (cfg.return_mode) begin
               if (arrived) begin
                  done_in = 1'b1;
               end
               rsp.loop_select = 1'b1;
               rsp.loop_error  = cfg.return_target - req.joint_pos;
            end else begin
               rsp.loop_error = setpoint_ff - req.joint_speed;
            end
         end
         default: phase_in = phase_ff;
      endcase
      rsp.phase   = phase_in;
      rsp.success = done_in;
   end

   assign done = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_START;
         stall_ff    <= '0;
         first_ff    <= '0;
         setpoint_ff <= '0;
         done_ff     <= 1'b0;
      end else if (fire) begin
         phase_ff    <= phase_in;
         stall_ff    <= stall_in;
         first_ff    <= first_in;
         setpoint_ff <= setpoint_in;
         done_ff     <= done_in;
      end
   end

endmodule

// File: src/hard_stop_homing_sequencer.sv
// Hard-stop homing sequencer: one request per control tick, one response per request.
// A request is held in an input register, the step logic works out the tick in a
// single pass and the response lands in an output register, so requests stream at
// one per clock while responses are taken. rsp_valid rises when the response is
// loaded from the step logic into the output register.
// The input register frees up whenever the output register is empty or being taken,
// which keeps the input side moving while a finished response waits; only a held-off
// rsp_ready with both registers full stalls req_ready.
// The joint is driven at search_speed until STALL_TICKS+1 slow ticks in a row (in the
// positive phase a halted actuator does not count), then a new offset is written;
// in centre mode the negative stop is searched too and the offset centers on the
// midpoint. With return_mode set the position loop then drives the joint to
// return_target and success rises once it is within arrive_tolerance.
// Csr writes are taken at any time but belong in idle periods; indexes 6 and 7 are ignored.
module hard_stop_homing_sequencer (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [hsh_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [hsh_pkg::DATA_W-1:0]            csr_wdata,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [hsh_pkg::DATA_W-1:0]     req_joint_speed,
   input  logic signed [hsh_pkg::DATA_W-1:0]     req_joint_pos,
   input  logic signed [hsh_pkg::DATA_W-1:0]     req_actuator_pos,
   input  logic signed [hsh_pkg::DATA_W-1:0]     req_offset_now,
   input  logic                                  req_halted,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_loop_select,
   output logic signed [hsh_pkg::DATA_W-1:0]     rsp_loop_error,
   output logic                                  rsp_offset_write,
   output logic signed [hsh_pkg::DATA_W-1:0]     rsp_offset_new,
   output logic [1:0]                            rsp_phase,
   output logic                                  rsp_success
);
   import hsh_pkg::*;

   cfg_type cfg;
   req_type req_ff, req_in;
   logic    req_valid_ff;
   rsp_type rsp_ff, step_rsp;
   logic    rsp_valid_ff;
   logic    out_free;
   logic    advance;
   logic    take;
   logic    step_done;

   // output register can load when empty or being drained this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   // tick moves from input register through the step logic
   assign advance   = req_valid_ff && out_free;
   assign req_ready = !req_valid_ff || advance;
   assign take      = req_valid && req_ready;

   assign req_in.joint_speed  = req_joint_speed;
   assign req_in.joint_pos    = req_joint_pos;
   assign req_in.actuator_pos = req_actuator_pos;
   assign req_in.offset_now   = req_offset_now;
   assign req_in.halted       = req_halted;

   hsh_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   hsh_step u_step (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .req   (req_ff),
      .cfg   (cfg),
      .rsp   (step_rsp),
      .done  (step_done)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         req_ff <= req_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= advance;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_loop_select  = rsp_ff.loop_select;
   assign rsp_loop_error   = rsp_ff.loop_error;
   assign rsp_offset_write = rsp_ff.offset_write;
   assign rsp_offset_new   = rsp_ff.offset_new;
   assign rsp_phase        = rsp_ff.phase;
   assign rsp_success      = rsp_ff.success;

   // offset is only ever written on the tick that enters the calibrated phase
   a_write_cal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.offset_write) |-> (rsp_ff.phase == PH_CAL))
      else $error("offset write outside calibrated phase");

   // offset value is zero unless it is being written
   a_offset_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.offset_write) |-> (rsp_ff.offset_new == '0))
      else $error("offset value without write");

   // success is sticky across ticks
   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      step_done |=> step_done)
      else $error("success dropped");

   // response success matches the step state right after the tick
   a_success_track: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_ff.success == step_done))
      else $error("response success out of step with state");

endmodule

// File: tb/hard_stop_homing_sequencer_tb.sv
`timescale 1ns / 1ps

module hard_stop_homing_sequencer_tb;
   import hsh_pkg::*;

   // watchdog: far beyond the slowest legal run
   localparam int unsigned CYCLE_LIMIT = 400000;
   // rough number of ticks the whole run aims for
   localparam int unsigned TICK_BUDGET = 1150;
   // csr indexes past the last register, the block must ignore them
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   // flavors of generated search ticks
   typedef enum {TK_SLOW, TK_FAST, TK_HALTED, TK_NOISE} tick_kind_type;

   // ---------------------------------------------------------------
   // clock, reset and block ports, every input known from time zero
   // ---------------------------------------------------------------
   logic                     clock            = 1'b0;
   logic                     reset            = 1'b1;
   logic                     csr_valid        = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index        = '0;
   logic [DATA_W-1:0]        csr_wdata        = '0;
   logic                     req_valid        = 1'b0;
   logic                     req_ready;
   logic signed [DATA_W-1:0] req_joint_speed  = '0;
   logic signed [DATA_W-1:0] req_joint_pos    = '0;
   logic signed [DATA_W-1:0] req_actuator_pos = '0;
   logic signed [DATA_W-1:0] req_offset_now   = '0;
   logic                     req_halted       = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready        = 1'b0;
   logic                     rsp_loop_select;
   logic signed [DATA_W-1:0] rsp_loop_error;
   logic                     rsp_offset_write;
   logic signed [DATA_W-1:0] rsp_offset_new;
   logic [1:0]               rsp_phase;
   logic                     rsp_success;

   // ---------------------------------------------------------------
   // homing predictor state, a private copy of the sequencer
   // ---------------------------------------------------------------
   cfg_type                  homing_cfg;
   phase_type                cur_phase  = PH_START;
   int                       stall_left = 0;
   logic signed [DATA_W-1:0] first_stop = '0;
   logic signed [DATA_W-1:0] speed_sp   = '0;
   logic                     done_latch = 1'b0;

   // predicted responses, oldest first
   rsp_type                  tick_outcomes[$];

   int unsigned ticks_sent     = 0;
   int unsigned ticks_checked  = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;
   int unsigned rx_hold        = 0;
   bit          gaps_on        = 1'b1;

   always #10 clock = ~clock;

   hard_stop_homing_sequencer DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_joint_speed  (req_joint_speed),
      .req_joint_pos    (req_joint_pos),
      .req_actuator_pos (req_actuator_pos),
      .req_offset_now   (req_offset_now),
      .req_halted       (req_halted),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_loop_select  (rsp_loop_select),
      .rsp_loop_error   (rsp_loop_error),
      .rsp_offset_write (rsp_offset_write),
      .rsp_offset_new   (rsp_offset_new),
      .rsp_phase        (rsp_phase),
      .rsp_success      (rsp_success)
   );

   // ---------------------------------------------------------------
   // one control tick of the sequencer, updates the private state
   // ---------------------------------------------------------------
   function automatic rsp_type homing_step(input req_type t);
      rsp_type r;
      longint  spd_mag;
      longint  pos_gap;
      longint  stop_sum;
      logic    slow;
      r = '0;
      // exact magnitude, so the most negative speed is never slow
      spd_mag = longint'(t.joint_speed);
      if (spd_mag < 0) spd_mag = -spd_mag;
      slow = spd_mag < longint'({1'b0, homing_cfg.stall_speed_limit});
      case (cur_phase)
         PH_START: begin
            // arm the search, no loop runs on this tick
            speed_sp   = homing_cfg.search_speed;
            stall_left = int'(STALL_TICKS);
            cur_phase  = PH_POS;
         end
         PH_POS, PH_NEG: begin
            // a halted actuator breaks the slow streak only while searching positive
            if (slow && !(cur_phase == PH_POS && t.halted)) stall_left--;
            else stall_left = int'(STALL_TICKS);
            if (stall_left < 0) begin
               speed_sp = '0;
               if (cur_phase == PH_POS && homing_cfg.centre_mode) begin
                  // remember the positive stop, turn around
                  first_stop = t.actuator_pos;
                  stall_left = int'(STALL_TICKS);
                  speed_sp   = -homing_cfg.search_speed;
                  cur_phase  = PH_NEG;
               end else begin
                  if (cur_phase == PH_POS) begin
                     r.offset_new = t.offset_now - t.actuator_pos;
                  end else begin
                     // floor of half the exact 33-bit sum of both stops
                     stop_sum = longint'(first_stop) + longint'(t.actuator_pos);
                     r.offset_new = t.offset_now - DATA_W'(stop_sum >>> 1);
                  end
                  r.offset_write = 1'b1;
                  cur_phase = PH_CAL;
                  if (!homing_cfg.return_mode) done_latch = 1'b1;
               end
            end
            // error uses the setpoint as updated on this very tick
            r.loop_error = speed_sp - t.joint_speed;
         end
         default: begin
            if (homing_cfg.return_mode) begin
               pos_gap = longint'(t.joint_pos) - longint'(homing_cfg.return_target);
               if (pos_gap < 0) pos_gap = -pos_gap;
               if (pos_gap < longint'({1'b0, homing_cfg.arrive_tolerance})) done_latch = 1'b1;
               r.loop_select = 1'b1;
               r.loop_error  = homing_cfg.return_target - t.joint_pos;
            end else begin
               r.loop_error = speed_sp - t.joint_speed;
            end
         end
      endcase
      r.phase   = cur_phase;
      r.success = done_latch;
      return r;
   endfunction

   function automatic req_type tick_of(input logic [DATA_W-1:0] speed, pos, apos, offs,
                                       input logic halt);
      req_type t;
      t.joint_speed  = speed;
      t.joint_pos    = pos;
      t.actuator_pos = apos;
      t.offset_now   = offs;
      t.halted       = halt;
      return t;
   endfunction

   // random tick; slow and fast kinds land on the matching side of the stall limit
   function automatic req_type make_tick(input tick_kind_type kind);
      req_type           t;
      logic [DATA_W-1:0] mag;
      logic [DATA_W-1:0] lim;
      lim = {1'b0, homing_cfg.stall_speed_limit};
      t.joint_speed = $urandom;
      t.joint_pos   = $urandom;
      t.offset_now  = $urandom;
      t.halted      = $urandom_range(1);
      // lean on the extremes so the midpoint sum overflows 32 bits now and then
      case ($urandom_range(7))
         0: t.actuator_pos = 32'h7FFF_FFFF;
         1: t.actuator_pos = 32'h8000_0000;
         2: t.actuator_pos = 32'hFFFF_FFFF;
         default: t.actuator_pos = $urandom;
      endcase
      if (kind == TK_FAST) begin
         mag = $urandom_range(32'h7FFF_FFFF, lim);
         t.joint_speed = ($urandom_range(15) == 0) ? 32'h8000_0000 :
                         ($urandom_range(1) ? -mag : mag);
      end else if (kind != TK_NOISE && lim != 0) begin
         mag = $urandom_range(lim - 1, 0);
         t.joint_speed = $urandom_range(1) ? -mag : mag;
         if (kind == TK_HALTED) t.halted = 1'b1;
         else if (cur_phase == PH_POS) t.halted = 1'b0;
      end
      return t;
   endfunction

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 100) $display("mismatch at %0t ns: %s", $time, what);
   endtask

   // ---------------------------------------------------------------
   // request side: random idle cycles, then hold valid until taken
   // ---------------------------------------------------------------
   task automatic send_tick(input req_type t);
      while (gaps_on && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_joint_speed  <= t.joint_speed;
      req_joint_pos    <= t.joint_pos;
      req_actuator_pos <= t.actuator_pos;
      req_offset_now   <= t.offset_now;
      req_halted       <= t.halted;
      do @(posedge clock); while (!req_ready);
      // request taken at this edge, predict its response now
      tick_outcomes.push_back(homing_step(t));
      ticks_sent++;
   endtask

   // drop valid and wait for every outstanding response, plus the pipeline depth
   task automatic settle();
      req_valid <= 1'b0;
      while (tick_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // csr write, mirrored into the predictor with the register widths applied
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_CENTRE_MODE: homing_cfg.centre_mode       = value[0];
         CSR_RETURN_MODE: homing_cfg.return_mode       = value[0];
         CSR_STALL_LIMIT: homing_cfg.stall_speed_limit = value[LIMIT_W-1:0];
         CSR_SEARCH_SPD:  homing_cfg.search_speed      = value;
         CSR_RETURN_TGT:  homing_cfg.return_target     = value;
         CSR_ARRIVE_TOL:  homing_cfg.arrive_tolerance  = value[LIMIT_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // response side: random stalls, plus a long hold-off on request
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (rx_hold != 0) begin
         rx_hold   <= rx_hold - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(gaps_on && $urandom_range(99) < 9);
      end
   end

   // compare every accepted response against the oldest prediction
   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (tick_outcomes.size() == 0) begin
            flag_mismatch("response with no request outstanding");
         end else begin
            want = tick_outcomes.pop_front();
            if (rsp_loop_select !== want.loop_select)
               flag_mismatch($sformatf("tick %0d loop_select got %0d want %0d",
                                       ticks_checked, rsp_loop_select, want.loop_select));
            if (rsp_loop_error !== want.loop_error)
               flag_mismatch($sformatf("tick %0d loop_error got %h want %h",
                                       ticks_checked, rsp_loop_error, want.loop_error));
            if (rsp_offset_write !== want.offset_write)
               flag_mismatch($sformatf("tick %0d offset_write got %0d want %0d",
                                       ticks_checked, rsp_offset_write, want.offset_write));
            if (rsp_offset_new !== want.offset_new)
               flag_mismatch($sformatf("tick %0d offset_new got %h want %h",
                                       ticks_checked, rsp_offset_new, want.offset_new));
            if (rsp_phase !== want.phase)
               flag_mismatch($sformatf("tick %0d phase got %0d want %0d",
                                       ticks_checked, rsp_phase, want.phase));
            if (rsp_success !== want.success)
               flag_mismatch($sformatf("tick %0d success got %0d want %0d",
                                       ticks_checked, rsp_success, want.success));
         end
         ticks_checked++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // every register once, junk in the upper bits, spare indexes ignored
   task automatic test_register_setup();
      settle();
      // centre mode decides single or double stop for this whole run
      csr_write(CSR_CENTRE_MODE, ($urandom & 32'hFFFF_FFFE) | 32'($urandom_range(1)));
      csr_write(CSR_RETURN_MODE, 32'hFFFF_FFFF);
      // bit 31 falls off the 31-bit limit, leaving 1.0
      csr_write(CSR_STALL_LIMIT, 32'h8001_0000);
      csr_write(CSR_SEARCH_SPD,  32'h7FFF_FFFF);
      csr_write(CSR_RETURN_TGT,  32'h0000_0000);
      csr_write(CSR_ARRIVE_TOL,  32'h8001_0000);
      csr_write(CSR_SPARE_LO,    $urandom);
      csr_write(CSR_SPARE_HI,    32'hFFFF_FFFF);
   endtask

   // first tick only arms the search
   task automatic test_start_tick();
      send_tick(make_tick(TK_NOISE));
   endtask

   // speed around the stall limit, position extremes, halted in positive search
   task automatic test_search_extremes();
      // halted actuator holds the streak at full count
      send_tick(tick_of(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1));
      send_tick(tick_of(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0));
      // just inside the limit on both sides
      send_tick(tick_of(32'h0000_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0));
      send_tick(tick_of(32'hFFFF_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0));
      // exactly on the limit is not slow
      send_tick(tick_of(32'h0001_0000, $urandom, $urandom, $urandom, 1'b0));
      send_tick(tick_of(32'hFFFF_0000, $urandom, $urandom, $urandom, 1'b0));
      send_tick(tick_of(32'h8000_0000, $urandom, $urandom, $urandom, 1'b1));
      send_tick(tick_of(32'h7FFF_FFFF, $urandom, $urandom, $urandom, 1'b0));
      // zero limit never counts as slow
      settle();
      csr_write(CSR_STALL_LIMIT, 32'h0000_0000);
      send_tick(tick_of(32'h0000_0000, $urandom, $urandom, $urandom, 1'b0));
      send_tick(tick_of(32'h0000_0000, $urandom, $urandom, $urandom, 1'b0));
      // widest limit: only the most negative speed and its neighbors stay fast
      settle();
      csr_write(CSR_STALL_LIMIT, 32'h7FFF_FFFF);
      send_tick(tick_of(32'h8000_0000, $urandom, $urandom, $urandom, 1'b0));
      send_tick(tick_of(32'h8000_0001, $urandom, $urandom, $urandom, 1'b0));
      send_tick(tick_of(32'h7FFF_FFFF, $urandom, $urandom, $urandom, 1'b0));
   endtask

   // slow streaks of random length broken by fast or halted ticks until the stop is hit
   task automatic run_search(input phase_type ph);
      int run_len;
      int tries;
      tries = 0;
      while (cur_phase == ph) begin
         // after a few misses force a streak long enough to stall
         run_len = (tries >= 5) ? 130 : $urandom_range(130, 20);
         for (int i = 0; i < run_len && cur_phase == ph; i++)
            send_tick(make_tick((tries < 5 && $urandom_range(99) < 2) ? TK_NOISE : TK_SLOW));
         if (cur_phase == ph)
            send_tick(make_tick((ph == PH_POS && $urandom_range(1)) ? TK_HALTED : TK_FAST));
         tries++;
      end
   endtask

   task automatic test_search_random();
      settle();
      // half the runs negate the most negative speed on the turn-around
      csr_write(CSR_SEARCH_SPD, $urandom_range(1) ? 32'h8000_0000 : $urandom);
      csr_write(CSR_STALL_LIMIT, $urandom_range(32'h00FF_FFFF, 1));
      // mostly keep the return move so the arrival logic gets exercised
      csr_write(CSR_RETURN_MODE, ($urandom & 32'hFFFF_FFFE) | 32'($urandom_range(3) != 0));
      run_search(PH_POS);
      settle();
      csr_write(CSR_STALL_LIMIT, $urandom_range(32'h7FFF_FFFF, 1));
      run_search(PH_NEG);
   endtask

   // position loop corners once calibrated
   task automatic test_calibrated_extremes();
      settle();
      csr_write(CSR_RETURN_MODE, 32'h0000_0001);
      csr_write(CSR_RETURN_TGT,  32'h7FFF_FFFF);
      csr_write(CSR_ARRIVE_TOL,  32'h7FFF_FFFF);
      // gap of 2^32-1 is outside even the widest tolerance, error wraps
      send_tick(tick_of($urandom, 32'h8000_0000, $urandom, $urandom, 1'b1));
      settle();
      csr_write(CSR_RETURN_TGT, 32'h8000_0000);
      csr_write(CSR_ARRIVE_TOL, 32'h0000_0000);
      // sitting on target with zero tolerance is still not arrived
      send_tick(tick_of($urandom, 32'h8000_0000, $urandom, $urandom, 1'b0));
      settle();
      csr_write(CSR_RETURN_MODE, 32'h0000_0000);
      // velocity loop against the zeroed setpoint
      send_tick(tick_of(32'h8000_0000, $urandom, $urandom, $urandom, 1'b0));
   endtask

   // calibrated segments with fresh targets; one without idling, one under back-pressure
   task automatic test_calibrated_random();
      int                seg;
      req_type           t;
      logic [DATA_W-1:0] miss;
      seg = 0;
      while (seg < 6 || ticks_sent + 10 < TICK_BUDGET) begin
         settle();
         gaps_on = (seg != 2);
         csr_write(CSR_RETURN_MODE, ($urandom & 32'hFFFF_FFFE) | 32'($urandom_range(3) != 0));
         csr_write(CSR_RETURN_TGT, $urandom);
         csr_write(CSR_ARRIVE_TOL, $urandom_range(32'h0001_0000, 1));
         // receiver holds off while requests keep coming, the block backs up
         if (seg == 4) rx_hold <= 80;
         repeat (60) begin
            t = make_tick(TK_NOISE);
            // near misses just outside the tolerance
            if ($urandom_range(2) == 0) begin
               miss = {1'b0, homing_cfg.arrive_tolerance} + $urandom_range(500);
               t.joint_pos = $urandom_range(1) ? homing_cfg.return_target + miss :
                                                 homing_cfg.return_target - miss;
            end
            send_tick(t);
         end
         seg++;
      end
      gaps_on = 1'b1;
   endtask

   // arrival edge, then success stays up
   task automatic test_arrival();
      logic [DATA_W-1:0] goal;
      goal = $urandom_range(32'h7000_0000);
      settle();
      csr_write(CSR_RETURN_MODE, 32'h0000_0001);
      csr_write(CSR_RETURN_TGT,  goal);
      csr_write(CSR_ARRIVE_TOL,  32'd1000);
      // on the tolerance edge, not there yet
      send_tick(tick_of($urandom, goal + 32'd1000, $urandom, $urandom, 1'b0));
      // one inside
      send_tick(tick_of($urandom, goal - 32'd999, $urandom, $urandom, 1'b1));
      // far away again, success is sticky
      send_tick(tick_of($urandom, $urandom, $urandom, $urandom, 1'b0));
      settle();
      csr_write(CSR_RETURN_MODE, 32'h0000_0000);
      send_tick(tick_of($urandom, $urandom, $urandom, $urandom, 1'b1));
   endtask

   initial begin
      // register values after reset
      homing_cfg = '{centre_mode: 1'b0, return_mode: 1'b0,
                     stall_speed_limit: 31'd65536, search_speed: 32'sd65536,
                     return_target: '0, arrive_tolerance: 31'd65536};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_setup();
      test_start_tick();
      test_search_extremes();
      test_search_random();
      test_calibrated_extremes();
      test_calibrated_random();
      test_arrival();

      // drain, then a few quiet cycles to catch stray responses
      settle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && tick_outcomes.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/hsh_pkg.sv
src/hsh_csr.sv
src/hsh_step.sv
src/hard_stop_homing_sequencer.sv
tb/hard_stop_homing_sequencer_tb.sv
